FILE: rtl/core/ber_tlv_stream_parser_top_assert.svh
// Assertion macros for the BER-TLV stream parser, empty when SYNTH is defined.
`ifndef BER_TLV_STREAM_PARSER_TOP_ASSERT_SVH
`define BER_TLV_STREAM_PARSER_TOP_ASSERT_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define BTLV_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("btlv: check failed");
// Condition in one cycle implies a consequence in the next cycle.
`define BTLV_ASSERT_NEXT(label, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error("btlv: sequence check failed");
`else
`define BTLV_ASSERT(label, prop)
`define BTLV_ASSERT_NEXT(label, cond, conseq)
`endif
`endif

FILE: rtl/core/btlv_pkg.sv
// Shared types and constants of the BER-TLV stream parser.
package btlv_pkg;

	localparam int DEF_MAX_TAG_BYTES    = 4;
	localparam int DEF_MAX_LENGTH_BYTES = 4;

	localparam logic [7:0] TAG_MORE_MASK  = 8'h1F;
	localparam logic [7:0] CONS_BIT       = 8'h20;
	localparam logic [7:0] LONG_BIT       = 8'h80;
	localparam logic [7:0] LEN_COUNT_MASK = 8'h7F;

	// Parser phase, one-hot
	typedef enum logic [4:0] {
		PH_TAG_FIRST = 5'b00001,
		PH_TAG_NEXT  = 5'b00010,
		PH_LEN_FIRST = 5'b00100,
		PH_LEN_LONG  = 5'b01000,
		PH_VALUE     = 5'b10000
	} btlv_phase_t;

	typedef enum logic [1:0] {
		ROLE_TAG      = 2'd0,
		ROLE_LEN      = 2'd1,
		ROLE_LEN_LONG = 2'd2,
		ROLE_VALUE    = 2'd3
	} btlv_role_t;

	typedef enum logic [1:0] {
		ERR_NONE        = 2'd0,
		ERR_SHORT_VALUE = 2'd1,
		ERR_TRUNCATED   = 2'd2,
		ERR_BAD_COUNT   = 2'd3
	} btlv_err_t;

	// Per-item status from the step logic to the top level
	typedef struct packed {
		btlv_role_t role;
		logic       tag_done;
		logic       constructed;
		logic       len_done;
		logic       vlast;
		btlv_err_t  err;
		logic       restart;
	} btlv_flags_t;

endpackage

FILE: rtl/core/btlv_step.sv
// Combinational next-state and classification logic for one stream byte.
module btlv_step #(
	parameter int MAX_TAG_BYTES    = btlv_pkg::DEF_MAX_TAG_BYTES,
	parameter int MAX_LENGTH_BYTES = btlv_pkg::DEF_MAX_LENGTH_BYTES,
	parameter int TW  = 8 * MAX_TAG_BYTES,
	parameter int LW  = 8 * MAX_LENGTH_BYTES,
	parameter int TCW = $clog2(MAX_TAG_BYTES + 1),
	parameter int LCW = $clog2(MAX_LENGTH_BYTES + 1)
) (
	input  btlv_pkg::btlv_phase_t phase_q,
	input  logic [TW-1:0]         tag_acc_q,
	input  logic [TCW-1:0]        tag_cnt_q,
	input  logic                  cons_q,
	input  logic [LCW-1:0]        len_left_q,
	input  logic [LW-1:0]         len_acc_q,
	input  logic [LW-1:0]         val_rem_q,
	input  logic [7:0]            data_byte,
	input  logic                  end_of_stream,
	output btlv_pkg::btlv_phase_t phase_u,
	output logic [TW-1:0]         tag_acc_u,
	output logic [TCW-1:0]        tag_cnt_u,
	output logic                  cons_u,
	output logic [LCW-1:0]        len_left_u,
	output logic [LW-1:0]         len_acc_u,
	output logic [LW-1:0]         val_rem_u,
	output btlv_pkg::btlv_flags_t flags
);
	import btlv_pkg::*;

	// Decode one byte against the current phase
	always_comb begin
		logic [6:0]    n;
		logic [LW-1:0] rem_dec;
		n       = data_byte[6:0] & LEN_COUNT_MASK[6:0];
		rem_dec = val_rem_q;
		phase_u    = phase_q;
		tag_acc_u  = tag_acc_q;
		tag_cnt_u  = tag_cnt_q;
		cons_u     = cons_q;
		len_left_u = len_left_q;
		len_acc_u  = len_acc_q;
		val_rem_u  = val_rem_q;
		flags      = '0;
		flags.role = ROLE_TAG;
		flags.err  = ERR_NONE;
		case (phase_q)
			PH_TAG_FIRST: begin
				len_acc_u  = '0;
				len_left_u = '0;
				val_rem_u  = '0;
				tag_acc_u  = TW'(data_byte);
				tag_cnt_u  = TCW'(1);
				cons_u     = (data_byte & CONS_BIT) != 8'h00;
				if ((data_byte & TAG_MORE_MASK) != TAG_MORE_MASK) begin
					flags.tag_done = 1'b1;
					phase_u        = PH_LEN_FIRST;
				end else if (MAX_TAG_BYTES <= 1) begin
					flags.err = ERR_TRUNCATED;
				end else begin
					phase_u = PH_TAG_NEXT;
				end
			end
			PH_TAG_NEXT: begin
				tag_acc_u = (tag_acc_q << 8) | TW'(data_byte);
				tag_cnt_u = tag_cnt_q + TCW'(1);
				if ((data_byte & LONG_BIT) == 8'h00) begin
					flags.tag_done = 1'b1;
					phase_u        = PH_LEN_FIRST;
				end else if (tag_cnt_u >= TCW'(MAX_TAG_BYTES)) begin
					flags.err = ERR_TRUNCATED;
				end
			end
			PH_LEN_FIRST: begin
				flags.role = ROLE_LEN;
				if ((data_byte & LONG_BIT) == 8'h00) begin
					len_acc_u      = LW'(data_byte);
					flags.len_done = 1'b1;
				end else begin
					len_acc_u = '0;
					if (n == 7'd0 || n > 7'(MAX_LENGTH_BYTES)) begin
						flags.err = ERR_BAD_COUNT;
					end else begin
						len_left_u = n[LCW-1:0];
						phase_u    = PH_LEN_LONG;
					end
				end
			end
			PH_LEN_LONG: begin
				flags.role = ROLE_LEN_LONG;
				len_acc_u  = (len_acc_q << 8) | LW'(data_byte);
				len_left_u = len_left_q - LCW'(1);
				if (len_left_u == '0) begin
					flags.len_done = 1'b1;
				end
			end
			PH_VALUE: begin
				flags.role = ROLE_VALUE;
				if (val_rem_q != '0) begin
					rem_dec = val_rem_q - LW'(1);
				end
				val_rem_u = rem_dec;
				if (rem_dec == '0) begin
					flags.vlast = 1'b1;
					phase_u     = PH_TAG_FIRST;
				end
			end
			default: begin
				phase_u = PH_TAG_FIRST;
			end
		endcase

		// Length complete: go to value bytes or back to a tag
		if (flags.len_done) begin
			if (cons_q || len_acc_u == '0) begin
				phase_u = PH_TAG_FIRST;
			end else begin
				val_rem_u = len_acc_u;
				phase_u   = PH_VALUE;
			end
		end

		// End of stream inside a record
		if (flags.err == ERR_NONE && end_of_stream) begin
			if (phase_u == PH_VALUE) begin
				flags.err = ERR_SHORT_VALUE;
			end else if (phase_u != PH_TAG_FIRST) begin
				flags.err = ERR_TRUNCATED;
			end
		end

		flags.constructed = cons_u;
		flags.restart     = (flags.err != ERR_NONE) || end_of_stream;
	end

endmodule

FILE: rtl/core/ber_tlv_stream_parser_top.sv
// Top level of the BER-TLV stream parser: input stage, parse state and result register.
//
// Channel  Dir  tdata                 tuser       tlast
// s_       in   data_byte             -           end_of_stream
// m_       out  tag/length fields     byte_role   value_last
//
// One byte per cycle sustained unless the result side stalls; each item passes through the
// input register, then the result register. The parse state updates in the cycle an
// item moves from the input register to the result register.
// Reset clears the input and result valid flags and returns parsing to a tag.
// A stalled result holds its register; the input register still takes one item.
`include "ber_tlv_stream_parser_top_assert.svh"
module ber_tlv_stream_parser_top #(
	parameter int MAX_TAG_BYTES    = btlv_pkg::DEF_MAX_TAG_BYTES,
	parameter int MAX_LENGTH_BYTES = btlv_pkg::DEF_MAX_LENGTH_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [31:0] tag_value, [32] tag_done, [33] is_constructed, [65:34] length_value,
	// [66] length_done, [68:67] error_code, [71:69] zero
	output logic [71:0] m_tdata,
	output logic [1:0]  m_tuser,   // [1:0] byte_role
	output logic        m_tlast
);
	import btlv_pkg::*;

	localparam int TW  = 8 * MAX_TAG_BYTES;
	localparam int LW  = 8 * MAX_LENGTH_BYTES;
	localparam int TCW = $clog2(MAX_TAG_BYTES + 1);
	localparam int LCW = $clog2(MAX_LENGTH_BYTES + 1);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eos_s1;
	logic        out_valid_q;
	logic        adv;

	btlv_phase_t    phase_q, phase_u;
	logic [TW-1:0]  tag_acc_q, tag_acc_u;
	logic [TCW-1:0] tag_cnt_q, tag_cnt_u;
	logic           cons_q, cons_u;
	logic [LCW-1:0] len_left_q, len_left_u;
	logic [LW-1:0]  len_acc_q, len_acc_u;
	logic [LW-1:0]  val_rem_q, val_rem_u;
	btlv_flags_t    flags;

	// Move an item to the result side when the result register is free
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	btlv_step #(
		.MAX_TAG_BYTES    (MAX_TAG_BYTES),
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
		.TW               (TW),
		.LW               (LW),
		.TCW              (TCW),
		.LCW              (LCW)
	) u_step (
		.phase_q       (phase_q),
		.tag_acc_q     (tag_acc_q),
		.tag_cnt_q     (tag_cnt_q),
		.cons_q        (cons_q),
		.len_left_q    (len_left_q),
		.len_acc_q     (len_acc_q),
		.val_rem_q     (val_rem_q),
		.data_byte     (byte_s1),
		.end_of_stream (eos_s1),
		.phase_u       (phase_u),
		.tag_acc_u     (tag_acc_u),
		.tag_cnt_u     (tag_cnt_u),
		.cons_u        (cons_u),
		.len_left_u    (len_left_u),
		.len_acc_u     (len_acc_u),
		.val_rem_u     (val_rem_u),
		.flags         (flags)
	);

	// Parse state: advance per item, drop back to a tag on error or end of stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TAG_FIRST;
			tag_acc_q  <= '0;
			tag_cnt_q  <= '0;
			cons_q     <= 1'b0;
			len_left_q <= '0;
			len_acc_q  <= '0;
			val_rem_q  <= '0;
		end else if (adv) begin
			if (flags.restart) begin
				phase_q    <= PH_TAG_FIRST;
				tag_acc_q  <= '0;
				tag_cnt_q  <= '0;
				cons_q     <= 1'b0;
				len_left_q <= '0;
				len_acc_q  <= '0;
				val_rem_q  <= '0;
			end else begin
				phase_q    <= phase_u;
				tag_acc_q  <= tag_acc_u;
				tag_cnt_q  <= tag_cnt_u;
				cons_q     <= cons_u;
				len_left_q <= len_left_u;
				len_acc_q  <= len_acc_u;
				val_rem_q  <= val_rem_u;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, values before any restart clearing
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata[31:0]  <= 32'(tag_acc_u);
			m_tdata[32]    <= flags.tag_done;
			m_tdata[33]    <= flags.constructed;
			m_tdata[65:34] <= 32'(len_acc_u);
			m_tdata[66]    <= flags.len_done;
			m_tdata[68:67] <= flags.err;
			m_tdata[71:69] <= 3'b000;
			m_tuser        <= flags.role;
			m_tlast        <= flags.vlast;
		end
	end

	`BTLV_ASSERT_NEXT(a_err_restart, adv && flags.err != ERR_NONE, phase_q == PH_TAG_FIRST && tag_cnt_q == '0)
	`BTLV_ASSERT(a_value_owed, phase_q != PH_VALUE || val_rem_q != '0)
	`BTLV_ASSERT(a_long_count, phase_q != PH_LEN_LONG || (len_left_q != '0 && len_left_q <= LCW'(MAX_LENGTH_BYTES)))
	`BTLV_ASSERT(a_stall_blocks, !(valid_s1 && out_valid_q && !m_tready) || !s_tready)
	`BTLV_ASSERT(a_last_is_value, !(m_tvalid && m_tlast) || m_tuser == ROLE_VALUE)

endmodule
